/* src/flv_avc_payload_extractor_macros.svh */
// Assertion helpers for the payload extractor.
// Both sample on the rising clock edge and are quiet while reset is applied.
`ifndef FLV_AVC_PAYLOAD_EXTRACTOR_MACROS_SVH
`define FLV_AVC_PAYLOAD_EXTRACTOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FAP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FAP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/fap_pkg.sv */
`default_nettype none

package fap_pkg;

	typedef enum logic [8:0] {
		PH_HDR   = 9'b000000001,
		PH_NLEN  = 9'b000000010,
		PH_NDATA = 9'b000000100,
		PH_SEEK  = 9'b000001000,
		PH_COUNT = 9'b000010000,
		PH_LHI   = 9'b000100000,
		PH_LLO   = 9'b001000000,
		PH_SDATA = 9'b010000000,
		PH_DONE  = 9'b100000000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_OK    = 2'd1,
		KIND_TRUNC = 2'd2
	} kind_t;

	// Index of the final byte of the tag header and of the NALU size field.
	localparam logic [2:0] HDR_LAST  = 3'd4;
	localparam logic [2:0] NLEN_LAST = 3'd3;
	localparam int         KF_BIT    = 4;

	localparam logic [7:0] SEEK_MASK      = 8'hFC;
	localparam logic [7:0] SPS_COUNT_MASK = 8'h1F;
	localparam logic [7:0] START_CODE_TAIL = 8'h01;
	localparam logic [2:0] START_CODE_LEN  = 3'd4;

endpackage

`default_nettype wire

/* src/flv_avc_payload_extractor.sv */
// FLV AVC payload extractor.
// The tag channel (tag_valid, tag_stall, in_byte, in_last) takes the body of one
// video tag a byte per request, in_last marking its final byte. The result channel
// (res_valid, res_stall and the result fields) gives the Annex B stream: passed-through
// NALU bytes, or parameter sets each preceded by the start code 00 00 00 01, and one
// status result (done or truncated) after the final byte. run_last marks the last
// result caused by one input byte.
// An accepted byte is registered in the input register, then decoded into the result
// register. Throughput: one byte per cycle while the result register is free; bytes
// with no result never wait. Each byte owns the result register until all its results
// (up to five, after a set's second length byte) are taken, so a start code holds off
// the tag channel.
// While the receiver stalls, the result held stays put. Bytes that yield no result
// still pass through the parser; the next byte that yields one waits in the input
// register, and tag_stall rises.
// Reset returns the parser to the tag header and drops any buffered request; the
// input and result valid flags go low at once.
`default_nettype none
`include "flv_avc_payload_extractor_macros.svh"

module flv_avc_payload_extractor import fap_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       tag_valid,
	output logic            tag_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic [7:0]      out_byte,
	output logic [1:0]      kind,
	output logic            keyframe,
	output logic            from_sequence_header,
	output logic            run_last
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Parser state
	phase_t      phase_q;
	logic [2:0]  idx_q;
	logic [31:0] accum_q;
	logic [31:0] rem_q;
	logic [7:0]  sets_q;
	logic        pps_q;
	logic        kf_q;
	logic        nalu_q;

	// Result register
	logic       valid_s2;
	logic [2:0] n_s2;
	logic [2:0] body_s2;
	logic [2:0] pos_s2;
	logic       sc_s2;
	logic [7:0] byte_s2;
	kind_t      status_s2;
	logic       kf_s2;
	logic       sh_s2;

	// Next state
	phase_t      phase_d;
	logic [2:0]  idx_d;
	logic [31:0] accum_d;
	logic [31:0] rem_d;
	logic [7:0]  sets_d;
	logic        pps_d;
	logic        kf_d;
	logic        nalu_d;
	logic [7:0]  count_w;
	logic        set_end;
	logic        list_end;
	logic        has_sc;
	logic        has_data;
	logic [2:0]  body_d;
	logic [2:0]  n_d;
	logic        known;
	kind_t       status_d;

	logic advance;
	logic s2_done;
	logic s2_free;
	logic in_body;

	always_comb begin
		phase_d  = phase_q;
		idx_d    = idx_q;
		accum_d  = accum_q;
		rem_d    = rem_q;
		sets_d   = sets_q;
		pps_d    = pps_q;
		kf_d     = kf_q;
		nalu_d   = nalu_q;
		count_w  = pps_q ? byte_s1 : (byte_s1 & SPS_COUNT_MASK);
		set_end  = 1'b0;
		list_end = 1'b0;
		has_sc   = 1'b0;
		has_data = 1'b0;
		unique case (phase_q)
			PH_HDR: begin
				if (idx_q == 3'd0) kf_d = byte_s1[KF_BIT];
				if (idx_q == 3'd1) nalu_d = byte_s1[0];
				idx_d = idx_q + 3'd1;
				if (idx_q >= HDR_LAST) begin
					idx_d   = '0;
					phase_d = nalu_d ? PH_NLEN : PH_SEEK;
				end
			end
			PH_NLEN: begin
				accum_d = {accum_q[23:0], byte_s1};
				idx_d   = idx_q + 3'd1;
				if (idx_q >= NLEN_LAST) begin
					idx_d   = '0;
					rem_d   = accum_d;
					phase_d = (accum_d != '0) ? PH_NDATA : PH_DONE;
				end
			end
			PH_NDATA: begin
				has_data = 1'b1;
				rem_d    = rem_q - 32'd1;
				if (rem_d == '0) phase_d = PH_DONE;
			end
			PH_SEEK: begin
				if ((byte_s1 & SEEK_MASK) == SEEK_MASK) begin
					pps_d   = 1'b0;
					phase_d = PH_COUNT;
				end
			end
			PH_COUNT: begin
				sets_d = count_w;
				if (count_w != '0) phase_d = PH_LHI;
				else list_end = 1'b1;
			end
			PH_LHI: begin
				accum_d = {24'd0, byte_s1};
				phase_d = PH_LLO;
			end
			PH_LLO: begin
				accum_d = {16'd0, accum_q[7:0], byte_s1};
				has_sc  = 1'b1;
				rem_d   = accum_d;
				if (accum_d != '0) phase_d = PH_SDATA;
				else set_end = 1'b1;
			end
			PH_SDATA: begin
				has_data = 1'b1;
				rem_d    = rem_q - 32'd1;
				if (rem_d == '0) set_end = 1'b1;
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		if (set_end) begin
			sets_d = sets_q - 8'd1;
			if (sets_d != '0) phase_d = PH_LHI;
			else list_end = 1'b1;
		end
		// The SPS list is followed by the PPS list; after that the tag is complete.
		if (list_end) begin
			if (pps_q) begin
				phase_d = PH_DONE;
			end else begin
				pps_d   = 1'b1;
				phase_d = PH_COUNT;
			end
		end

		body_d   = has_sc ? START_CODE_LEN : {2'b00, has_data};
		n_d      = body_d + {2'b00, last_s1};
		known    = !(phase_d == PH_HDR && idx_d < 3'd2);
		status_d = (phase_d == PH_DONE) ? KIND_OK : KIND_TRUNC;
	end

	assign s2_done   = valid_s2 && !res_stall && (pos_s2 == n_s2 - 3'd1);
	assign s2_free   = !valid_s2 || s2_done;
	// A byte that yields no result only updates the parser, so it need not wait.
	assign advance   = valid_s1 && ((n_d == '0) || s2_free);
	assign tag_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tag_valid && !tag_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_valid && !tag_stall) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			idx_q   <= '0;
			accum_q <= '0;
			rem_q   <= '0;
			sets_q  <= '0;
			pps_q   <= 1'b0;
			kf_q    <= 1'b0;
			nalu_q  <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q <= PH_HDR;
				idx_q   <= '0;
				accum_q <= '0;
				rem_q   <= '0;
				sets_q  <= '0;
				pps_q   <= 1'b0;
				kf_q    <= 1'b0;
				nalu_q  <= 1'b0;
			end else begin
				phase_q <= phase_d;
				idx_q   <= idx_d;
				accum_q <= accum_d;
				rem_q   <= rem_d;
				sets_q  <= sets_d;
				pps_q   <= pps_d;
				kf_q    <= kf_d;
				nalu_q  <= nalu_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			pos_s2   <= '0;
		end else if (advance && (n_d != '0)) begin
			valid_s2 <= 1'b1;
			pos_s2   <= '0;
		end else if (s2_done) begin
			valid_s2 <= 1'b0;
		end else if (valid_s2 && !res_stall) begin
			pos_s2 <= pos_s2 + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (n_d != '0)) begin
			n_s2      <= n_d;
			body_s2   <= body_d;
			sc_s2     <= has_sc;
			byte_s2   <= byte_s1;
			status_s2 <= status_d;
			kf_s2     <= kf_d;
			sh_s2     <= known & ~nalu_d;
		end
	end

	assign in_body              = pos_s2 < body_s2;
	assign res_valid            = valid_s2;
	assign keyframe             = kf_s2;
	assign from_sequence_header = sh_s2;
	assign run_last             = pos_s2 == n_s2 - 3'd1;

	always_comb begin
		if (!in_body) begin
			out_byte = '0;
			kind     = status_s2;
		end else if (sc_s2) begin
			out_byte = (pos_s2 == START_CODE_LEN - 3'd1) ? START_CODE_TAIL : 8'h00;
			kind     = KIND_DATA;
		end else begin
			out_byte = byte_s2;
			kind     = KIND_DATA;
		end
	end

	`FAP_ASSERT_NOW(a_pos_in_range, res_valid, pos_s2 < n_s2, "result position past its count")
	`FAP_ASSERT_NOW(a_start_code_tail, res_valid && sc_s2 && pos_s2 == 3'd3,
		out_byte == START_CODE_TAIL && kind == KIND_DATA, "start code does not end in 01")
	`FAP_ASSERT_NEXT(a_tag_end_resets, advance && last_s1,
		phase_q == PH_HDR && idx_q == 3'd0 && !pps_q, "parser not back at header after tag end")

endmodule

`default_nettype wire
